FILE: rtl/tftp_transfer_controller_core_assert.svh
// Assertion macros for the TFTP transfer controller RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef TFTP_TRANSFER_CONTROLLER_CORE_ASSERT_SVH
`define TFTP_TRANSFER_CONTROLLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define TFTC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tftc assertion failed");
// next-cycle implication, checked out of reset
`define TFTC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tftc assertion failed");
`else
`define TFTC_ASSERT_IMP(name, ante, cons)
`define TFTC_ASSERT_NXT(name, ante, cons)
`endif
`endif

FILE: rtl/tftc_pkg.sv
// Shared types and constants for the TFTP transfer controller.
// No dependencies; imported by tftc_step and the top level.
package tftc_pkg;

  // field widths
  localparam int ACT_W    = 2;
  localparam int OPC_W    = 8;
  localparam int BLK_W    = 16;
  localparam int PLEN_W   = 11;
  localparam int LEN_W    = 10;
  localparam int ECODE_W  = 8;
  localparam int TOTAL_W  = 32;
  localparam int RETRY_W  = 4;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 3;
  localparam int ROLE_W   = 2;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  // block size and derived limits
  localparam int BLOCK_BYTES = 512;
  localparam int HDR_BYTES   = 4;
  localparam logic [LEN_W-1:0]  BLOCK_LEN = LEN_W'(BLOCK_BYTES);
  localparam logic [PLEN_W-1:0] PKT_FULL  = PLEN_W'(BLOCK_BYTES + HDR_BYTES);
  localparam logic [PLEN_W-1:0] PKT_HDR   = PLEN_W'(HDR_BYTES);

  // packet opcodes
  localparam logic [OPC_W-1:0] OPC_DATA  = 8'd3;
  localparam logic [OPC_W-1:0] OPC_ACK   = 8'd4;
  localparam logic [OPC_W-1:0] OPC_ERROR = 8'd5;

  // event codes
  localparam logic [ACT_W-1:0] ACT_GET     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUT     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_PACKET  = 2'd3;

  // roles
  localparam logic [ROLE_W-1:0] ROLE_IDLE = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_GET  = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_PUT  = 2'd2;

  // write phases
  localparam logic [PHASE_W-1:0] PH_FIRST = 2'd0;
  localparam logic [PHASE_W-1:0] PH_NEXT  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LAST  = 2'd2;

  // send kinds
  localparam logic [KIND_W-1:0] K_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] K_RRQ    = 3'd1;
  localparam logic [KIND_W-1:0] K_WRQ    = 3'd2;
  localparam logic [KIND_W-1:0] K_ACK    = 3'd3;
  localparam logic [KIND_W-1:0] K_DATA   = 3'd4;
  localparam logic [KIND_W-1:0] K_RESEND = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_BUSY    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_SERVER  = 3'd2;
  localparam logic [STAT_W-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADACK  = 3'd4;
  localparam logic [STAT_W-1:0] ST_READERR = 3'd5;
  localparam logic [STAT_W-1:0] ST_IDLE    = 3'd6;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;
  localparam logic                 MODE_RST  = 1'b1;
  localparam logic [RETRY_W-1:0]   LIMIT_RST = 4'd6;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [OPC_W-1:0]   opcode;
    logic [BLK_W-1:0]   block_number;
    logic [PLEN_W-1:0]  packet_length;
    logic [LEN_W-1:0]   chunk_length;
    logic               read_error;
    logic [ECODE_W-1:0] server_error_code;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  send_kind;
    logic [BLK_W-1:0]   send_block;
    logic [LEN_W-1:0]   send_length;
    logic               mode_netascii;
    logic               adopt_port;
    logic [LEN_W-1:0]   store_length;
    logic [STAT_W-1:0]  status;
    logic [ECODE_W-1:0] error_code;
    logic [TOTAL_W-1:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [ROLE_W-1:0]  role;
    logic [PHASE_W-1:0] write_phase;
    logic [RETRY_W-1:0] retry_count;
    logic [BLK_W-1:0]   current_block;
    logic [TOTAL_W-1:0] total_bytes;
    logic               port_latched;
  } xfer_state_t;

endpackage

FILE: rtl/tftc_step.sv
// Next-state and result logic for one event of the transfer controller.
// Depends on tftc_pkg; purely combinational.
module tftc_step import tftc_pkg::*; (
  input  xfer_state_t        cur,
  input  in_item_t           item,
  input  logic               transfer_mode,
  input  logic [RETRY_W-1:0] retry_limit,
  output xfer_state_t        nxt,
  output out_item_t          res
);

  logic [LEN_W-1:0]  chunk_c;
  logic [LEN_W-1:0]  store_c;
  logic [LEN_W-1:0]  add_amt;
  logic [STAT_W-1:0] status;
  logic              put_go;
  logic              pkt_full;

  // clamp the source chunk and size the received payload
  assign chunk_c  = (item.chunk_length > BLOCK_LEN) ? BLOCK_LEN : item.chunk_length;
  assign pkt_full = (item.packet_length >= PKT_FULL);

  always_comb begin
    if (pkt_full) begin
      store_c = BLOCK_LEN;
    end else if (item.packet_length >= PKT_HDR) begin
      store_c = LEN_W'(item.packet_length - PKT_HDR);
    end else begin
      store_c = '0;
    end
  end

  // event decode
  always_comb begin
    nxt     = cur;
    res     = '0;
    status  = ST_BUSY;
    add_amt = '0;
    put_go  = 1'b0;

    unique case (item.action) inside
      ACT_GET, ACT_PUT: begin
        nxt      = '0;
        nxt.role = (item.action == ACT_GET) ? ROLE_GET : ROLE_PUT;
        res.send_kind     = (item.action == ACT_GET) ? K_RRQ : K_WRQ;
        res.mode_netascii = ~transfer_mode;
      end
      default: begin
        if (cur.role == ROLE_IDLE) begin
          status = ST_IDLE;
        end else if (item.action == ACT_TIMEOUT) begin
          if (cur.retry_count >= retry_limit) begin
            nxt.role = ROLE_IDLE;
            status   = ST_TIMEOUT;
          end else begin
            res.send_kind   = K_RESEND;
            nxt.retry_count = cur.retry_count + 1'b1;
          end
        end else begin
          // received packet
          if (cur.role == ROLE_PUT) begin
            nxt.retry_count = '0;
          end
          if (item.opcode == OPC_ERROR) begin
            nxt.role       = ROLE_IDLE;
            status         = ST_SERVER;
            res.error_code = item.server_error_code;
          end else if (cur.role == ROLE_GET) begin
            if (!cur.port_latched) begin
              nxt.port_latched = 1'b1;
              res.adopt_port   = 1'b1;
            end
            if (item.opcode == OPC_DATA) begin
              nxt.current_block = item.block_number;
              res.send_kind     = K_ACK;
              res.send_block    = item.block_number;
              res.store_length  = store_c;
              add_amt           = store_c;
              if (!pkt_full) begin
                nxt.role = ROLE_IDLE;
                status   = ST_DONE;
              end
            end
          end else if (item.opcode == OPC_ACK) begin
            if (cur.write_phase == PH_FIRST) begin
              if (item.block_number == '0) begin
                nxt.port_latched = 1'b1;
                res.adopt_port   = 1'b1;
                put_go           = 1'b1;
              end else begin
                nxt.role = ROLE_IDLE;
                status   = ST_BADACK;
              end
            end else if (item.block_number != cur.current_block) begin
              nxt.role = ROLE_IDLE;
              status   = ST_BADACK;
            end else if (cur.write_phase == PH_NEXT) begin
              put_go = 1'b1;
            end else begin
              // last ack, and the unused phase code behaves the same
              nxt.role = ROLE_IDLE;
              status   = ST_DONE;
            end
          end
        end
      end
    endcase

    // next data block of a put; the chunk counts even on a read error
    if (put_go) begin
      add_amt = chunk_c;
      if (chunk_c != BLOCK_LEN) begin
        nxt.write_phase   = PH_LAST;
        nxt.current_block = cur.current_block + 1'b1;
        res.send_kind     = K_DATA;
        res.send_block    = cur.current_block + 1'b1;
        res.send_length   = chunk_c;
      end else if (item.read_error) begin
        nxt.role = ROLE_IDLE;
        status   = ST_READERR;
      end else begin
        nxt.write_phase   = PH_NEXT;
        nxt.current_block = cur.current_block + 1'b1;
        res.send_kind     = K_DATA;
        res.send_block    = cur.current_block + 1'b1;
        res.send_length   = chunk_c;
      end
    end

    nxt.total_bytes = nxt.total_bytes + TOTAL_W'(add_amt);
    res.status      = status;
    res.byte_count  = nxt.total_bytes;
  end

endmodule

FILE: rtl/tftp_transfer_controller_core.sv
// TFTP transfer controller top level: input register, transfer state, result register.
// Depends on tftc_pkg, tftc_step and tftp_transfer_controller_core_assert.svh.
//
//   channel  direction  handshake             payload
//   in_      in         in_valid / in_ready   in_item  (in_item_t)
//   out_     out        out_valid / out_ready out_item (out_item_t)
//   cfg_     in         cfg_we                cfg_index, cfg_data
//
// An event's result is loaded after the request is accepted: the request sits
// in the input register, and the edge on which it advances applies the state
// update and captures the result. One event per cycle is sustained while the
// result is drained; the transfer state update is the only loop.
// A stalled result holds the result register; one more event waits in the
// input register, then in_ready drops. Reset (rst_n low, synchronous) empties
// both registers and returns the state and configuration to their defaults.
`include "tftp_transfer_controller_core_assert.svh"
module tftp_transfer_controller_core import tftc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  in_item_t           in_r;
  logic               in_valid_r;
  out_item_t          out_r;
  logic               out_valid_r;
  xfer_state_t        st_r;
  xfer_state_t        st_nxt;
  out_item_t          res_nxt;
  logic               mode_r;
  logic [RETRY_W-1:0] limit_r;
  logic               adv;

  // a request moves forward when the result slot is free or being drained
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  tftc_step u_step (
    .cur           (st_r),
    .item          (in_r),
    .transfer_mode (mode_r),
    .retry_limit   (limit_r),
    .nxt           (st_nxt),
    .res           (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[0];
        CFG_LIMIT: limit_r <= cfg_data[RETRY_W-1:0];
        default:   ;
      endcase
    end
  end

  // a terminal status always leaves the controller idle
  `TFTC_ASSERT_NXT(a_end_to_idle, adv && (res_nxt.status != ST_BUSY), st_r.role == ROLE_IDLE)
  // a request that moves forward always produces a result
  `TFTC_ASSERT_NXT(a_adv_fills_out, adv, out_valid_r)
  // a start always resets the byte total and reports busy
  `TFTC_ASSERT_IMP(a_start_clears, adv && (in_r.action == ACT_GET || in_r.action == ACT_PUT),
                   res_nxt.byte_count == '0 && res_nxt.status == ST_BUSY)

endmodule
